### rtl/core/p1305_pkg.sv
// Shared types and constants for the Poly1305 tag engine.
package p1305_pkg;

  localparam int LIMB_W    = 26;
  localparam int NUM_LIMBS = 5;
  localparam int ACC_W     = 131;
  localparam int H_W       = 132;
  localparam int HTOP_W    = 28;
  localparam int RR_W      = 29;
  localparam int PROD_W    = 57;
  localparam int COL_W     = 61;
  localparam int CARRY_W   = 35;

  localparam logic [2:0]  LAST_LIMB  = 3'(NUM_LIMBS - 1);
  localparam logic [4:0]  FULL_BYTES = 5'd16;
  localparam logic [7:0]  PAD_BYTE   = 8'h01;
  localparam logic [2:0]  P_FOLD     = 3'd5;

  localparam logic [63:0] R_CLAMP_LOW  = 64'h0FFF_FFFC_0FFF_FFFF;
  localparam logic [63:0] R_CLAMP_HIGH = 64'h0FFF_FFFC_0FFF_FFFC;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t REG_R_LOW  = 2'd0;
  localparam cfg_idx_t REG_R_HIGH = 2'd1;
  localparam cfg_idx_t REG_S_LOW  = 2'd2;
  localparam cfg_idx_t REG_S_HIGH = 2'd3;

  typedef struct packed {
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic [4:0]  byte_count;
    logic        message_last;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] tag_low;
    logic [63:0] tag_high;
  } out_beat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

### rtl/core/p1305_mul.sv
// Limb-serial multiplier: one 26-bit limb product per cycle, column by column.
module p1305_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start_i,
  input  logic [p1305_pkg::H_W-1:0]      h_i,
  input  logic [127:0]                   r_i,
  output p1305_pkg::mul_stat_t           stat_o,
  output logic [129:0]                   res_o,
  output logic [p1305_pkg::CARRY_W-1:0]  carry_o
);
  import p1305_pkg::*;

  logic [H_W-1:0]     h_r;
  logic               busy_r;
  logic               done_r;
  logic               prod_vld_r;
  logic               prod_end_r;
  logic               prod_fin_r;
  logic [2:0]         col_r;
  logic [2:0]         j_r;
  logic [PROD_W-1:0]  prod_r;
  logic [COL_W-1:0]   col_acc_r;
  logic [CARRY_W-1:0] carry_r;
  logic [129:0]       res_r;

  logic [HTOP_W-1:0]  h_limb [NUM_LIMBS];
  logic [LIMB_W-1:0]  r_limb [NUM_LIMBS];
  logic [HTOP_W-1:0]  h_sel;
  logic [LIMB_W-1:0]  r_sel;
  logic [RR_W-1:0]    rr;
  logic [3:0]         k_wrap;
  logic [2:0]         k_idx;
  logic               wrap;
  logic [PROD_W-1:0]  prod_c;
  logic [COL_W-1:0]   col_total;

  for (genvar g = 0; g < NUM_LIMBS - 1; g++) begin : g_limbs
    assign h_limb[g] = {2'b00, h_r[g*LIMB_W +: LIMB_W]};
    assign r_limb[g] = r_i[g*LIMB_W +: LIMB_W];
  end
  assign h_limb[NUM_LIMBS-1] = h_r[H_W-1 -: HTOP_W];
  assign r_limb[NUM_LIMBS-1] = {2'b00, r_i[127:104]};

  // Column i collects h[j] * r[i-j]; terms that wrap past the top limb pick up
  // the factor of five from 2^130 = 5 mod p.
  assign wrap   = (j_r > col_r);
  assign k_wrap = {1'b0, col_r} + 4'd5 - {1'b0, j_r};
  assign k_idx  = wrap ? k_wrap[2:0] : (col_r - j_r);
  assign h_sel  = h_limb[j_r];
  assign r_sel  = r_limb[k_idx];
  assign rr     = wrap ? ({3'b000, r_sel} + {1'b0, r_sel, 2'b00}) : {3'b000, r_sel};
  assign prod_c = PROD_W'(h_sel) * PROD_W'(rr);

  assign col_total = col_acc_r + COL_W'(prod_r) + COL_W'(carry_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      done_r     <= 1'b0;
      prod_vld_r <= 1'b0;
      prod_end_r <= 1'b0;
      prod_fin_r <= 1'b0;
      col_r      <= '0;
      j_r        <= '0;
    end else begin
      prod_vld_r <= busy_r;
      prod_end_r <= (j_r == LAST_LIMB);
      prod_fin_r <= (col_r == LAST_LIMB);
      if (start_i) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        col_r  <= '0;
        j_r    <= '0;
      end else if (busy_r) begin
        if (j_r == LAST_LIMB) begin
          j_r <= '0;
          if (col_r == LAST_LIMB) begin
            busy_r <= 1'b0;
          end else begin
            col_r <= col_r + 3'd1;
          end
        end else begin
          j_r <= j_r + 3'd1;
        end
      end
      if (prod_vld_r && prod_end_r && prod_fin_r) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      h_r       <= h_i;
      col_acc_r <= '0;
      carry_r   <= '0;
    end else if (prod_vld_r) begin
      if (prod_end_r) begin
        // Finished limb enters at the top; after five columns limb 0 sits lowest.
        res_r     <= {col_total[LIMB_W-1:0], res_r[129:LIMB_W]};
        carry_r   <= col_total[COL_W-1:LIMB_W];
        col_acc_r <= '0;
      end else begin
        col_acc_r <= col_acc_r + COL_W'(prod_r);
      end
    end
    if (busy_r) begin
      prod_r <= prod_c;
    end
  end

  assign stat_o.busy = busy_r | prod_vld_r;
  assign stat_o.done = done_r;
  assign res_o       = res_r;
  assign carry_o     = carry_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> !(busy_r || prod_vld_r))
    else $error("multiply started while a product is in flight");

  a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(prod_vld_r && prod_end_r && prod_fin_r))
    else $error("done raised without the final column product");

  a_issue_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(col_r == LAST_LIMB && j_r == LAST_LIMB))
    else $error("product issue stopped before the last limb pair");

endmodule

### rtl/core/poly1305_mac.sv
// Poly1305 tag engine: key registers, block padding, absorb, reduction and tag output.
//
// Usage: load the four 64-bit key words through the cfg_ write port while the
// block is idle (r is clamped internally). Message blocks then arrive as input
// beats on in_valid/in_ready, 16 bytes each, little endian. A beat with
// message_last set closes the message; its byte_count (0 to 16, larger values
// act as 16) says how many bytes are real, and the block is padded with 0x01.
// That beat produces exactly one tag beat on out_valid/out_ready.
// Sequencing: a message block is finished before the next beat can be taken,
// since in_ready is high only in the idle state. The 25 limb products are
// computed in turn by the single 28x29 multiplier in p1305_mul, followed by the
// product register, the column carry and the fold of the top carry. A final block
// with data then passes the reduction state and the tag state, which finishes the
// reduction and adds s; a final beat with no bytes skips the multiply and goes
// straight to the reduction state.
// Reset clears the key registers and the accumulator. A tag that is not taken
// does not block new input beats, but the next tag waits in the final state
// until the output register is free.
module poly1305_mac (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  p1305_pkg::cfg_idx_t   cfg_index,
  input  logic [63:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  p1305_pkg::in_beat_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output p1305_pkg::out_beat_t  out_data
);
  import p1305_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_RED  = 4'b0100,
    S_TAG  = 4'b1000
  } state_t;

  state_t         state_r;
  state_t         state_nxt;
  logic [63:0]    r_low_r;
  logic [63:0]    r_high_r;
  logic [63:0]    s_low_r;
  logic [63:0]    s_high_r;
  logic [ACC_W-1:0] acc_r;
  logic           last_r;
  logic [129:0]   red_r;
  logic           out_valid_r;
  out_beat_t      out_data_r;

  logic           in_fire;
  logic [4:0]     n_sat;
  logic           full_blk;
  logic           empty_last;
  logic [127:0]   blk;
  logic [128:0]   msg;
  logic [H_W-1:0] h_in;
  logic [127:0]   r_clamped;
  logic           mul_start;
  mul_stat_t      mul_stat;
  logic [129:0]   mul_res;
  logic [CARRY_W-1:0] mul_carry;
  logic [CARRY_W+2:0] carry5;
  logic [ACC_W-1:0]   acc_fold;
  logic [129:0]   red_nxt;
  logic [130:0]   g_sum;
  logic [127:0]   h_final;
  logic [127:0]   tag_sum;
  logic           tag_go;

  // Key registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_low_r  <= '0;
      r_high_r <= '0;
      s_low_r  <= '0;
      s_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_R_LOW:  r_low_r  <= cfg_wdata;
        REG_R_HIGH: r_high_r <= cfg_wdata;
        REG_S_LOW:  s_low_r  <= cfg_wdata;
        REG_S_HIGH: s_high_r <= cfg_wdata;
      endcase
    end
  end

  assign r_clamped = {r_high_r & R_CLAMP_HIGH, r_low_r & R_CLAMP_LOW};

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign n_sat      = (in_data.byte_count > FULL_BYTES) ? FULL_BYTES : in_data.byte_count;
  assign full_blk   = !in_data.message_last || (n_sat == FULL_BYTES);
  assign empty_last = in_data.message_last && (n_sat == 5'd0);
  assign blk        = {in_data.block_high, in_data.block_low};

  // Bytes past the count become a single 0x01 followed by zeros. A full block
  // carries the 2^128 bit instead.
  always_comb begin
    msg[128] = full_blk;
    for (int b = 0; b < 16; b++) begin
      if (full_blk || (5'(b) < n_sat)) begin
        msg[8*b +: 8] = blk[8*b +: 8];
      end else if (5'(b) == n_sat) begin
        msg[8*b +: 8] = PAD_BYTE;
      end else begin
        msg[8*b +: 8] = 8'h00;
      end
    end
  end

  assign h_in      = {1'b0, acc_r} + {3'b000, msg};
  assign mul_start = in_fire && !empty_last;

  p1305_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mul_start),
    .h_i     (h_in),
    .r_i     (r_clamped),
    .stat_o  (mul_stat),
    .res_o   (mul_res),
    .carry_o (mul_carry)
  );

  // The carry out of the top column is worth 2^130, which folds back as times five.
  assign carry5   = {3'b000, mul_carry} + {1'b0, mul_carry, 2'b00};
  assign acc_fold = {1'b0, mul_res} + ACC_W'(carry5);

  // After a fold the accumulator is below 2^130 + 2^38, so folding bit 130 once
  // leaves a value below 2^130; one conditional subtraction of p then finishes it.
  assign red_nxt = acc_r[129:0] + (acc_r[130] ? 130'(P_FOLD) : 130'd0);
  assign g_sum   = {1'b0, red_r} + 131'(P_FOLD);
  assign h_final = g_sum[130] ? g_sum[127:0] : red_r[127:0];
  assign tag_sum = h_final + {s_high_r, s_low_r};

  assign tag_go = (state_r == S_TAG) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = empty_last ? S_RED : S_MUL;
        end
      end
      S_MUL: begin
        if (mul_stat.done) begin
          state_nxt = last_r ? S_RED : S_IDLE;
        end
      end
      S_RED: begin
        state_nxt = S_TAG;
      end
      S_TAG: begin
        if (tag_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        last_r <= in_data.message_last;
      end
      if ((state_r == S_MUL) && mul_stat.done) begin
        acc_r <= acc_fold;
      end else if (tag_go) begin
        acc_r <= '0;
      end
      if (tag_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RED) begin
      red_r <= red_nxt;
    end
    if (tag_go) begin
      out_data_r.tag_low  <= tag_sum[63:0];
      out_data_r.tag_high <= tag_sum[127:64];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && empty_last) |=> (state_r == S_RED))
    else $error("empty final beat did not go straight to reduction");

  a_tag_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_TAG))
    else $error("tag presented outside the tag state");

  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    tag_go |=> (acc_r == '0))
    else $error("accumulator not cleared after a tag");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mul_stat.busy)
    else $error("multiplier busy while the block is idle");

endmodule

### dv/tb_top.sv
// Self-checking testbench for the poly1305_mac tag engine.
module tb_top;
  import p1305_pkg::*;

  // The receiver hold-off in the pressure phase, the silence that the watchdog
  // tolerates, and the settling time after the last tag.
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_BLOCKS  = 250;

  // The Poly1305 prime 2^130 - 5.
  localparam logic [130:0] PRIME_130 = (131'd1 << 130) - 131'd5;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  logic [63:0] cfg_wdata;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  poly1305_mac dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Our own copy of the key registers. The accumulator is kept fully reduced
  // modulo the prime; the engine keeps it only partly reduced, but the tag only
  // depends on its value modulo the prime.
  logic [127:0] key_r = '0;
  logic [127:0] key_s = '0;
  logic [129:0] poly_acc = '0;

  in_beat_t  blocks_to_send[$];
  out_beat_t tags_due[$];

  int errors = 0;
  int quiet = 0;
  bit in_took = 1'b0;
  int send_idle_pct = 0;
  int rx_stall_pct = 0;
  bit rx_hold = 1'b0;

  // Absorbs one accepted beat into the accumulator and, on the final beat of a
  // message, forms the tag that the engine must return.
  function automatic void fold_block(in_beat_t b);
    logic [4:0]   n;
    logic [127:0] msg;
    logic [128:0] pad_bit;
    logic [128:0] blk;
    logic [127:0] r_clamped;
    logic [258:0] prod;
    logic [127:0] sum;
    out_beat_t    tag;
    n = (b.byte_count > FULL_BYTES) ? FULL_BYTES : b.byte_count;
    msg = {b.block_high, b.block_low};
    r_clamped = key_r & {R_CLAMP_HIGH, R_CLAMP_LOW};
    // Non-final beats are always full blocks, whatever their byte count says.
    // A short final block keeps its real bytes, gets the pad byte right after
    // them and no 2^128 bit.
    if (!b.message_last || n == FULL_BYTES) begin
      blk = {1'b1, msg};
    end else begin
      pad_bit = 129'(PAD_BYTE) << (8 * n);
      blk = (129'(msg) & (pad_bit - 129'd1)) | pad_bit;
    end
    // A final beat with no bytes adds nothing and skips the multiply.
    if (!b.message_last || n != 5'd0) begin
      prod = (259'(poly_acc) + 259'(blk)) * 259'(r_clamped);
      poly_acc = 130'(prod % 259'(PRIME_130));
    end
    if (b.message_last) begin
      sum = poly_acc[127:0] + key_s;
      tag.tag_low = sum[63:0];
      tag.tag_high = sum[127:64];
      tags_due.push_back(tag);
      poly_acc = '0;
    end
  endfunction

  // Monitor: everything is sampled at the rising edge, where the engine's
  // outputs still hold their values from before the edge. The tag is checked
  // before the input beat is folded in, so a tag that arrives with nothing
  // expected can never be matched against one queued in the same cycle.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
      quiet <= 0;
      poly_acc = '0;
    end else begin
      in_took <= in_valid && in_ready;
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (out_valid && out_ready) begin
        if (tags_due.size() == 0) begin
          $display("%0t: unexpected tag beat, expected none, got %h", $time, out_data);
          errors++;
        end else begin
          want = tags_due.pop_front();
          if (out_data.tag_low !== want.tag_low) begin
            $display("%0t: tag_low expected %h, got %h", $time, want.tag_low,
                     out_data.tag_low);
            errors++;
          end
          if (out_data.tag_high !== want.tag_high) begin
            $display("%0t: tag_high expected %h, got %h", $time, want.tag_high,
                     out_data.tag_high);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        fold_block(in_data);
      end
    end
  end

  // Driver: inputs change only at the falling edge. A beat on offer stays put
  // until the monitor has seen it accepted; only then may the next one go out,
  // possibly after a random gap.
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (blocks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= blocks_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // Ends the run if neither channel moves a beat for too long.
  initial begin : watchdog
    while (quiet < QUIET_LIMIT) @(negedge clk);
    $display("poly1305_mac verification failed");
    $finish;
  end

  task automatic write_key(cfg_idx_t idx, logic [63:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    case (idx)
      REG_R_LOW:  key_r[63:0] = value;
      REG_R_HIGH: key_r[127:64] = value;
      REG_S_LOW:  key_s[63:0] = value;
      REG_S_HIGH: key_s[127:64] = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_keys(logic [63:0] r_lo, logic [63:0] r_hi,
                           logic [63:0] s_lo, logic [63:0] s_hi);
    write_key(REG_R_LOW, r_lo);
    write_key(REG_R_HIGH, r_hi);
    write_key(REG_S_LOW, s_lo);
    write_key(REG_S_HIGH, s_hi);
  endtask

  // Waits at rising edges, where the driver never touches the send queue,
  // until every beat is out and every tag is back, then lets the engine settle.
  task automatic settle();
    while (blocks_to_send.size() != 0 || in_valid || tags_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void push_block(logic [63:0] lo, logic [63:0] hi,
                                     logic [4:0] count, logic last);
    in_beat_t b;
    b.block_low = lo;
    b.block_high = hi;
    b.byte_count = count;
    b.message_last = last;
    blocks_to_send.push_back(b);
  endfunction

  // Data words lean toward all zeros and all ones now and then.
  function automatic logic [63:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Queues one message: up to body_max full blocks and a final block whose
  // byte count is 0 to 16, or above 16 about a quarter of the time.
  function automatic int queue_message(int body_max);
    int body;
    body = $urandom_range(body_max);
    for (int i = 0; i < body; i++)
      push_block(pick_word(), pick_word(), 5'($urandom), 1'b0);
    push_block(pick_word(), pick_word(),
               ($urandom_range(3) == 0) ? 5'($urandom_range(31, 17))
                                        : 5'($urandom_range(16)), 1'b1);
    return body + 1;
  endfunction

  initial begin : stimulus
    int sent;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_R_LOW;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part with every key bit set, so r is at its clamped maximum.
    load_keys('1, '1, '1, '1);
    @(posedge clk);
    // A full non-final block whose byte count must be ignored, then a full
    // final block.
    push_block('1, '1, 5'd31, 1'b0);
    push_block('1, '1, FULL_BYTES, 1'b1);
    // An empty message: the tag is s alone.
    push_block('0, '0, 5'd0, 1'b1);
    // A final beat with no bytes after real data.
    push_block('1, '1, 5'd0, 1'b0);
    push_block('0, '0, 5'd0, 1'b1);
    // Short final blocks, with the pad byte landing on both halves and on the
    // boundary between them.
    push_block('1, '1, 5'd1, 1'b1);
    push_block('1, '1, 5'd7, 1'b1);
    push_block('1, '1, 5'd8, 1'b1);
    push_block('1, '1, 5'd9, 1'b1);
    push_block('1, '1, 5'd15, 1'b1);
    // Byte counts above 16 act as 16.
    push_block('1, '1, 5'd17, 1'b1);
    push_block('1, '1, 5'd31, 1'b1);
    push_block('0, '0, FULL_BYTES, 1'b1);
    // Several all-ones blocks drive the accumulator high before a short tail.
    push_block('1, '1, 5'd0, 1'b0);
    push_block('1, '1, 5'd0, 1'b0);
    push_block('1, '1, 5'd0, 1'b0);
    push_block('1, '1, 5'd15, 1'b1);
    settle();

    // Random phases: each one loads new keys, picks a pacing and sends whole
    // messages with random content.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_keys('0, '0, '0, '0);
        2: load_keys('1, '1, '0, '0);
        default: load_keys({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      @(posedge clk);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 82;
          rx_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          rx_stall_pct = 82;
        end
        default: begin
          send_idle_pct = 16;
          rx_stall_pct = 16;
        end
      endcase
      sent = 0;
      while (sent < PHASE_BLOCKS) sent += queue_message(6);
      settle();
    end

    // Back-pressure: short messages keep coming while the receiver refuses
    // tags for a long stretch, so the output register and then the final
    // state fill up and the engine has to stall its input.
    load_keys({$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
    @(posedge clk);
    send_idle_pct = 0;
    rx_stall_pct = 0;
    for (int m = 0; m < 30; m++) void'(queue_message(1));
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
    settle();

    if (errors == 0) begin
      $display("poly1305_mac verification clean");
    end else begin
      $display("poly1305_mac verification failed");
    end
    $finish;
  end

endmodule
